[rtl/gsfp_pkg.sv]
// Package for the gas sensor frame parser: status codes, frame constants
// and the struct passed from the framer to the output stage.
// No dependencies.
package gsfp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 4;
  localparam int unsigned RawW      = 16;
  localparam int unsigned ConcW     = 7;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned OutDataW  = 32;

  localparam logic [ByteW-1:0] StartByte  = 8'hFF;
  localparam logic [PosW-1:0]  PosFirst   = 4'd0;
  localparam logic [PosW-1:0]  PosHigh    = 4'd4;
  localparam logic [PosW-1:0]  PosLow     = 4'd5;
  localparam logic [PosW-1:0]  PosSum     = 4'd8;

  // floor(x / 1000) == (x * 67109) >> 26 for every 16-bit x
  localparam int unsigned      RecipShift = 26;
  localparam int unsigned      RecipW     = 17;
  localparam int unsigned      ProdW      = RawW + RecipW;
  localparam logic [RecipW-1:0] RecipK    = 17'd67109;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_START = 2'd1,
    STATUS_BAD_SUM   = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [RawW-1:0]     raw;
  } frame_close_t;

endpackage

[rtl/gsfp_framer.sv]
// Byte framer: tracks position, checksum and reading bytes of a nine-byte frame
// and registers the status and raw reading when a frame closes.
// Depends on gsfp_pkg.
module gsfp_framer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         byte_vld_i,
  output logic                         byte_rdy_o,
  input  logic [gsfp_pkg::ByteW-1:0]   byte_i,
  output logic                         cls_vld_o,
  input  logic                         cls_rdy_i,
  output gsfp_pkg::frame_close_t       cls_o
);

  logic [gsfp_pkg::PosW-1:0]  pos_q, pos_d;
  logic [gsfp_pkg::ByteW-1:0] sum_q, sum_d;
  logic                       start_q, start_d;
  logic [gsfp_pkg::ByteW-1:0] hi_q, hi_d;
  logic [gsfp_pkg::ByteW-1:0] lo_q, lo_d;
  logic                       cls_vld_q, cls_vld_d;
  gsfp_pkg::frame_close_t     cls_q, cls_d;
  logic                       accept;
  logic                       closing;
  logic [gsfp_pkg::ByteW-1:0] sum_chk;

  assign byte_rdy_o = !cls_vld_q || cls_rdy_i;
  assign accept     = byte_vld_i && byte_rdy_o;
  assign closing    = pos_q >= gsfp_pkg::PosSum;
  assign sum_chk    = sum_q + byte_i;

  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    start_d   = start_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    cls_vld_d = cls_vld_q && !cls_rdy_i;
    cls_d     = cls_q;
    if (accept) begin
      if (pos_q == gsfp_pkg::PosFirst) begin
        start_d = (byte_i == gsfp_pkg::StartByte);
        sum_d   = '0;
        pos_d   = pos_q + gsfp_pkg::PosW'(1);
      end else if (!closing) begin
        sum_d = sum_chk;
        if (pos_q == gsfp_pkg::PosHigh) begin
          hi_d = byte_i;
        end else if (pos_q == gsfp_pkg::PosLow) begin
          lo_d = byte_i;
        end
        pos_d = pos_q + gsfp_pkg::PosW'(1);
      end else begin
        cls_vld_d = 1'b1;
        cls_d.raw = {hi_q, lo_q};
        if (!start_q) begin
          cls_d.status = gsfp_pkg::STATUS_BAD_START;
        end else if (sum_chk != '0) begin
          cls_d.status = gsfp_pkg::STATUS_BAD_SUM;
        end else begin
          cls_d.status = gsfp_pkg::STATUS_OK;
        end
        pos_d   = gsfp_pkg::PosFirst;
        sum_d   = '0;
        start_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= gsfp_pkg::PosFirst;
      sum_q     <= '0;
      start_q   <= 1'b0;
      hi_q      <= '0;
      lo_q      <= '0;
      cls_vld_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      start_q   <= start_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      cls_vld_q <= cls_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

  assign cls_vld_o = cls_vld_q;
  assign cls_o     = cls_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= gsfp_pkg::PosSum)
    else $error("frame position out of range");

  a_close_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && closing |=> pos_q == gsfp_pkg::PosFirst && cls_vld_q)
    else $error("closing byte did not restart frame");

  a_start_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == gsfp_pkg::PosFirst |-> !start_q && sum_q == '0)
    else $error("frame state not cleared at frame start");

endmodule

[rtl/gas_sensor_frame_parser.sv]
// Gas sensor frame parser top level: nine-byte frames in, one result per frame out.
// The checksum word is registered in the framer, then in the output register.
// Throughput: one input word per cycle unless m_axis back-pressure drops s_axis_tready.
// Reset clears frame position, checksum state and both valid flags.
// Depends on gsfp_pkg and gsfp_framer.
module gas_sensor_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [1:0] frame_status, [17:2] raw_reading,
                                      // [24:18] concentration, [31:25] zero
);

  logic                                cls_vld;
  logic                                cls_rdy;
  gsfp_pkg::frame_close_t              cls;
  logic [gsfp_pkg::ProdW-1:0]          prod;
  logic [gsfp_pkg::ConcW-1:0]          conc;
  logic                                m_vld_q, m_vld_d;
  gsfp_pkg::status_e                   status_q;
  logic [gsfp_pkg::RawW-1:0]           raw_q;
  logic [gsfp_pkg::ConcW-1:0]          conc_q;

  gsfp_framer u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (s_axis_tvalid),
    .byte_rdy_o (s_axis_tready),
    .byte_i     (s_axis_tdata),
    .cls_vld_o  (cls_vld),
    .cls_rdy_i  (cls_rdy),
    .cls_o      (cls)
  );

  assign cls_rdy = !m_vld_q || m_axis_tready;
  assign prod    = gsfp_pkg::ProdW'(cls.raw) * gsfp_pkg::ProdW'(gsfp_pkg::RecipK);
  assign conc    = (cls.status == gsfp_pkg::STATUS_OK) ?
                   prod[gsfp_pkg::RecipShift +: gsfp_pkg::ConcW] : '0;
  assign m_vld_d = cls_rdy ? cls_vld : m_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cls_rdy && cls_vld) begin
      status_q <= cls.status;
      raw_q    <= cls.raw;
      conc_q   <= conc;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {{(gsfp_pkg::OutDataW - gsfp_pkg::ConcW - gsfp_pkg::RawW
                            - gsfp_pkg::StatusW){1'b0}},
                          conc_q, raw_q, status_q};

  a_conc_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && status_q != gsfp_pkg::STATUS_OK |-> conc_q == '0)
    else $error("concentration set on a bad frame");

  a_conc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q |-> conc_q <= gsfp_pkg::ConcW'(65))
    else $error("concentration above full scale");

  a_close_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_vld && cls_rdy |=> m_vld_q && raw_q == $past(cls.raw))
    else $error("closed frame not transferred to output");

endmodule

[tb/testbench.sv]
// Self-checking testbench for gas_sensor_frame_parser: streams nine-byte frames
// (good, bad start, bad checksum, noise) with random idling and stalls, and checks
// every result word against an in-bench frame predictor. Depends on gsfp_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RawPerUnit   = 1000;
  localparam int unsigned FrameLen     = 9;
  localparam int unsigned PhaseWords   = 175;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned DrainCycles  = 10;

  typedef struct packed {
    gsfp_pkg::status_e            status;
    logic [gsfp_pkg::RawW-1:0]    raw;
    logic [gsfp_pkg::ConcW-1:0]   conc;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  gas_sensor_frame_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  logic [7:0]      rx_words[$];
  frame_result_t   expected_frames[$];
  int unsigned     src_idle_pct = 0;
  int unsigned     sink_stall_pct = 0;
  int unsigned     mismatches = 0;
  logic            word_taken = 1'b0;

  // frame predictor state
  logic [gsfp_pkg::PosW-1:0]  frm_pos = gsfp_pkg::PosFirst;
  logic [gsfp_pkg::ByteW-1:0] frm_sum = '0;
  logic                       frm_start_ok = 1'b0;
  logic [gsfp_pkg::ByteW-1:0] rd_hi = '0;
  logic [gsfp_pkg::ByteW-1:0] rd_lo = '0;

  function automatic void parse_word(input logic [gsfp_pkg::ByteW-1:0] b);
    frame_result_t r;
    logic [gsfp_pkg::ByteW-1:0] want;
    if (frm_pos == gsfp_pkg::PosFirst) begin
      frm_start_ok = (b == gsfp_pkg::StartByte);
      frm_sum      = '0;
      frm_pos      = gsfp_pkg::PosFirst + 4'd1;
    end else if (frm_pos < gsfp_pkg::PosSum) begin
      frm_sum = frm_sum + b;
      if (frm_pos == gsfp_pkg::PosHigh) begin
        rd_hi = b;
      end else if (frm_pos == gsfp_pkg::PosLow) begin
        rd_lo = b;
      end
      frm_pos = frm_pos + 4'd1;
    end else begin
      want   = ~frm_sum + 8'd1;
      r.raw  = {rd_hi, rd_lo};
      r.conc = '0;
      if (!frm_start_ok) begin
        r.status = gsfp_pkg::STATUS_BAD_START;
      end else if (want != b) begin
        r.status = gsfp_pkg::STATUS_BAD_SUM;
      end else begin
        r.status = gsfp_pkg::STATUS_OK;
        r.conc   = gsfp_pkg::ConcW'(r.raw / RawPerUnit);
      end
      expected_frames.push_back(r);
      frm_pos      = gsfp_pkg::PosFirst;
      frm_sum      = '0;
      frm_start_ok = 1'b0;
    end
  endfunction

  function automatic void queue_frame(input logic [7:0] start, input logic [15:0] raw,
                                      input bit bad_sum);
    logic [7:0] f[FrameLen];
    logic [7:0] sum;
    sum  = '0;
    f[0] = start;
    for (int i = 1; i < FrameLen - 1; i++) begin
      f[i] = 8'($urandom_range(0, 255));
    end
    f[4] = raw[15:8];
    f[5] = raw[7:0];
    for (int i = 1; i < FrameLen - 1; i++) begin
      sum = sum + f[i];
    end
    f[8] = ~sum + 8'd1;
    if (bad_sum) begin
      f[8] = f[8] ^ 8'($urandom_range(1, 255));
    end
    foreach (f[i]) rx_words.push_back(f[i]);
  endfunction

  function automatic logic [15:0] pick_raw();
    int unsigned v;
    if ($urandom_range(0, 99) < 35) begin
      // land on either side of a ppm step
      v = $urandom_range(0, 65) * RawPerUnit + ($urandom_range(0, 1) ? 999 : 0);
      if ($urandom_range(0, 4) == 0) begin
        v = v + 1;
      end
      if (v > 65535) begin
        v = 65535;
      end
    end else begin
      v = $urandom_range(0, 65535);
    end
    return 16'(v);
  endfunction

  // source side
  always @(negedge clk_i) begin : drive
    logic       nv;
    logic [7:0] nd;
    nv = s_axis_tvalid && !word_taken;
    nd = s_axis_tdata;
    if (rst_ni && !nv && rx_words.size() > 0 &&
        $urandom_range(0, 99) >= src_idle_pct) begin
      nd = rx_words.pop_front();
      nv = 1'b1;
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // acceptance, prediction and result check
  always @(posedge clk_i) begin : monitor
    frame_result_t e;
    logic [1:0]    got_status;
    logic [15:0]   got_raw;
    logic [6:0]    got_conc;
    logic [6:0]    got_pad;
    word_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_word(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tdata[1:0];
        got_raw    = m_axis_tdata[17:2];
        got_conc   = m_axis_tdata[24:18];
        got_pad    = m_axis_tdata[31:25];
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t unexpected result word %h", $realtime, m_axis_tdata);
          end
        end else begin
          e = expected_frames.pop_front();
          if (got_status != e.status || got_raw != e.raw || got_conc != e.conc ||
              got_pad != '0) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t result mismatch: status exp %0d got %0d, raw exp %h got %h,",
                       $realtime, e.status, got_status, e.raw, got_raw);
              $display("  conc exp %0d got %0d, pad got %h",
                       e.conc, got_conc, got_pad);
            end
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned added;
    int unsigned kind;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: max reading, bad start with bad sum (start wins), bad sum with reading
    queue_frame(gsfp_pkg::StartByte, 16'hFFFF, 1'b0);
    queue_frame(8'h00, 16'd999, 1'b1);
    queue_frame(gsfp_pkg::StartByte, 16'd65000, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      @(posedge clk_i);
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      added = 0;
      while (added < PhaseWords) begin
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
          queue_frame(gsfp_pkg::StartByte, pick_raw(), 1'b0);
        end else if (kind < 77) begin
          queue_frame(8'($urandom_range(0, 254)), pick_raw(), 1'($urandom_range(0, 1)));
        end else if (kind < 90) begin
          queue_frame(gsfp_pkg::StartByte, pick_raw(), 1'b1);
        end else begin
          for (int i = 0; i < FrameLen; i++) begin
            rx_words.push_back(8'($urandom_range(0, 255)));
          end
        end
        added += FrameLen;
      end
      while (rx_words.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    end

    while (expected_frames.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/gsfp_pkg.sv
rtl/gsfp_framer.sv
rtl/gas_sensor_frame_parser.sv
tb/testbench.sv
